// ===== hw/rtl/nmu_pkg.sv =====
// ----------------------------------------------------------------------------
// Nadam moment update package
// Shared widths, register codes, reset values and pipeline records.
// ----------------------------------------------------------------------------
package nmu_pkg;

  localparam int FracBits  = 24;
  localparam int DataW     = 32;
  localparam int CfgW      = 25;
  localparam int CfgIdxW   = 3;

  // square root of v << FracBits
  localparam int RadW      = DataW + FracBits;
  localparam int SqrtSteps = RadW / 2;
  localparam int RootW     = SqrtSteps;
  localparam int RemW      = RootW + 2;

  // step division: magnitude * lr over bc * (root + eps)
  localparam int MagW      = 57;
  localparam int ProdW     = MagW + CfgW;
  localparam int DenW      = RootW + 1;
  localparam int DivW      = CfgW + DenW;
  localparam int DivSteps  = DataW + 1;

  localparam logic [CfgW-1:0] One = CfgW'(64'd1 << FracBits);
  localparam int EpsRound   = ((1 << FracBits) + 5000000) / 10000000;
  localparam logic [CfgW-1:0] EpsDefault = (EpsRound == 0) ? CfgW'(1) : CfgW'(EpsRound);

  localparam logic [CfgIdxW-1:0] CfgLr  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgB1  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgB2  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgEps = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgBc  = 3'd4;

  localparam logic [CfgW-1:0] LrReset  = 25'd16777;
  localparam logic [CfgW-1:0] B1Reset  = 25'd15099494;
  localparam logic [CfgW-1:0] B2Reset  = 25'd16760439;
  localparam logic [CfgW-1:0] EpsReset = 25'd2;
  localparam logic [CfgW-1:0] BcReset  = 25'd1677722;

  typedef struct packed {
    logic [DataW-1:0] m;
    logic [DataW-1:0] v;
    logic             neg;
  } nmu_res_t;

  typedef struct packed {
    nmu_res_t        res;
    logic [MagW-1:0] mag;
  } nmu_side_t;

endpackage

// ===== hw/rtl/nmu_sqrt.sv =====
// ----------------------------------------------------------------------------
// Nadam square root pipeline
// One result bit per stage: floor(sqrt(v << FracBits)), item data carried along.
// ----------------------------------------------------------------------------
module nmu_sqrt import nmu_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  nmu_side_t       in_side_i,
  output logic            out_valid_o,
  output nmu_side_t       out_side_o,
  output logic [RootW-1:0] out_root_o
);

  logic [SqrtSteps-1:0] valid_q;
  logic [RemW-1:0]      rem_q  [SqrtSteps];
  logic [RootW-1:0]     root_q [SqrtSteps];
  nmu_side_t            side_q [SqrtSteps];

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_stage
    logic             vin;
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    nmu_side_t        side_in;
    logic [RadW-1:0]  rad;
    logic [RemW+1:0]  rr;
    logic [RemW+1:0]  tt;
    logic [RemW-1:0]  rem_d;
    logic [RootW-1:0] root_d;

    if (k == 0) begin : g_first
      assign vin     = in_valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = in_side_i;
    end else begin : g_next
      assign vin     = valid_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign rad = {side_in.res.v, {FracBits{1'b0}}};
    assign rr  = {rem_in, rad[RadW-1-2*k -: 2]};
    assign tt  = {2'b00, root_in, 2'b01};

    always_comb begin
      if (rr >= tt) begin
        rem_d  = RemW'(rr - tt);
        root_d = {root_in[RootW-2:0], 1'b1};
      end else begin
        rem_d  = RemW'(rr);
        root_d = {root_in[RootW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= rem_d;
      root_q[k] <= root_d;
      side_q[k] <= side_in;
    end
  end

  assign out_valid_o = valid_q[SqrtSteps-1];
  assign out_side_o  = side_q[SqrtSteps-1];
  assign out_root_o  = root_q[SqrtSteps-1];

endmodule

// ===== hw/rtl/nmu_div.sv =====
// ----------------------------------------------------------------------------
// Nadam step divider
// Restoring division, one quotient bit per stage, item data carried along.
// ----------------------------------------------------------------------------
module nmu_div import nmu_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  nmu_res_t            in_res_i,
  input  logic                in_ovf_i,
  input  logic [DivW-1:0]     in_rem_i,
  input  logic [DivSteps-1:0] in_low_i,
  input  logic [DivW-1:0]     in_div_i,
  output logic                out_valid_o,
  output nmu_res_t            out_res_o,
  output logic                out_ovf_o,
  output logic [DivSteps-1:0] out_quot_o
);

  logic [DivSteps-1:0] valid_q;
  logic [DivW-1:0]     rem_q  [DivSteps];
  logic [DivSteps-1:0] low_q  [DivSteps];
  logic [DivW-1:0]     div_q  [DivSteps];
  logic [DivSteps-1:0] quot_q [DivSteps];
  logic                ovf_q  [DivSteps];
  nmu_res_t            res_q  [DivSteps];

  for (genvar k = 0; k < DivSteps; k++) begin : g_stage
    logic                vin;
    logic [DivW-1:0]     rem_in;
    logic [DivSteps-1:0] low_in;
    logic [DivW-1:0]     div_in;
    logic [DivSteps-1:0] quot_in;
    logic                ovf_in;
    nmu_res_t            res_in;
    logic [DivW:0]       rr;
    logic [DivW-1:0]     rem_d;
    logic [DivSteps-1:0] quot_d;

    if (k == 0) begin : g_first
      assign vin     = in_valid_i;
      assign rem_in  = in_rem_i;
      assign low_in  = in_low_i;
      assign div_in  = in_div_i;
      assign quot_in = '0;
      assign ovf_in  = in_ovf_i;
      assign res_in  = in_res_i;
    end else begin : g_next
      assign vin     = valid_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign low_in  = low_q[k-1];
      assign div_in  = div_q[k-1];
      assign quot_in = quot_q[k-1];
      assign ovf_in  = ovf_q[k-1];
      assign res_in  = res_q[k-1];
    end

    assign rr = {rem_in, low_in[DivSteps-1-k]};

    always_comb begin
      if (rr >= {1'b0, div_in}) begin
        rem_d  = DivW'(rr - {1'b0, div_in});
        quot_d = {quot_in[DivSteps-2:0], 1'b1};
      end else begin
        rem_d  = DivW'(rr);
        quot_d = {quot_in[DivSteps-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= rem_d;
      low_q[k]  <= low_in;
      div_q[k]  <= div_in;
      quot_q[k] <= quot_d;
      ovf_q[k]  <= ovf_in;
      res_q[k]  <= res_in;
    end
  end

  assign out_valid_o = valid_q[DivSteps-1];
  assign out_res_o   = res_q[DivSteps-1];
  assign out_ovf_o   = ovf_q[DivSteps-1];
  assign out_quot_o  = quot_q[DivSteps-1];

endmodule

// ===== hw/rtl/nadam_moment_update_core.sv =====
// ----------------------------------------------------------------------------
// Nadam moment update core
// Element-wise Nadam step: new moments and a saturated update per item.
// ----------------------------------------------------------------------------
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------
//   input    | start_i, busy_o         | gradient, old first/second moment
//   result   | valid_o (one cycle)     | new first/second moment, step value
//   config   | cfg_valid_i, cfg_ready_o| cfg_index_i, cfg_data_i
//
// One item per cycle; each result follows its start through the stages below.
// Pipeline: 4 moment stages, 28 square root stages, 3 denominator stages,
// 33 divider stages and the output register.
// busy_o stays low and cfg_ready_o high; reset clears all valid bits and
// returns the registers to their defaults. Results are never held.
// ----------------------------------------------------------------------------
module nadam_moment_update_core import nmu_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic signed [31:0]  gradient_i,
  input  logic signed [31:0]  old_first_moment_i,
  input  logic [31:0]         old_second_moment_i,
  output logic                valid_o,
  output logic signed [31:0]  new_first_moment_o,
  output logic [31:0]         new_second_moment_o,
  output logic signed [31:0]  step_value_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i
);

  localparam int Latency = 4 + SqrtSteps + 3 + DivSteps + 1;

  logic [CfgW-1:0] learning_rate_q, beta_first_q, beta_second_q, epsilon_q_q, bias_corr_q;
  logic [CfgW-1:0] b1, b2, omb1, omb2, eps_eff, bc_eff;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      learning_rate_q <= LrReset;
      beta_first_q    <= B1Reset;
      beta_second_q   <= B2Reset;
      epsilon_q_q     <= EpsReset;
      bias_corr_q     <= BcReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgLr:   learning_rate_q <= cfg_data_i;
        CfgB1:   beta_first_q    <= cfg_data_i;
        CfgB2:   beta_second_q   <= cfg_data_i;
        CfgEps:  epsilon_q_q     <= cfg_data_i;
        CfgBc:   bias_corr_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp betas to one, replace a zero epsilon or bias correction
  assign b1      = (beta_first_q > One) ? One : beta_first_q;
  assign b2      = (beta_second_q > One) ? One : beta_second_q;
  assign omb1    = One - b1;
  assign omb2    = One - b2;
  assign eps_eff = (epsilon_q_q == '0) ? EpsDefault : epsilon_q_q;
  assign bc_eff  = (bias_corr_q == '0) ? CfgW'(1) : bias_corr_q;

  // ---- stage 1: first products
  logic               v1_q;
  logic signed [57:0] b1m0_q, omb1g_q;
  logic [56:0]        b2v0_q;
  logic [63:0]        gsq_q;
  logic signed [31:0] g1_q;
  logic [31:0]        gmag;

  assign gmag = gradient_i[31] ? 32'(~gradient_i + 32'sd1) : gradient_i;

  always_ff @(posedge clk_i) begin
    b1m0_q  <= $signed({1'b0, b1}) * old_first_moment_i;
    omb1g_q <= $signed({1'b0, omb1}) * gradient_i;
    b2v0_q  <= b2 * old_second_moment_i;
    gsq_q   <= gmag * gmag;
    g1_q    <= gradient_i;
  end

  // ---- stage 2: new first moment, squared gradient
  logic               v2_q;
  logic signed [31:0] m2_q;
  logic [39:0]        gg2_q;
  logic [56:0]        b2v0_2_q;
  logic signed [57:0] omb1g2_q;
  logic signed [58:0] msum;
  logic signed [34:0] mfl;
  logic signed [31:0] msat;

  assign msum = b1m0_q + omb1g_q;
  assign mfl  = msum[58:FracBits];

  always_comb begin
    if (mfl[34:31] == 4'b0000 || mfl[34:31] == 4'b1111) begin
      msat = mfl[31:0];
    end else if (mfl[34]) begin
      msat = 32'sh8000_0000;
    end else begin
      msat = 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk_i) begin
    m2_q     <= msat;
    gg2_q    <= gsq_q[63:FracBits];
    b2v0_2_q <= b2v0_q;
    omb1g2_q <= omb1g_q;
  end

  // ---- stage 3: second products
  logic               v3_q;
  logic signed [31:0] m3_q;
  logic [63:0]        omb2gg_q;
  logic [56:0]        b2v0_3_q;
  logic signed [57:0] b1m_q, omb1g3_q;

  always_ff @(posedge clk_i) begin
    m3_q     <= m2_q;
    omb2gg_q <= omb2 * gg2_q;
    b2v0_3_q <= b2v0_2_q;
    b1m_q    <= $signed({1'b0, b1}) * m2_q;
    omb1g3_q <= omb1g2_q;
  end

  // ---- stage 4: new second moment, numerator magnitude
  logic               v4_q;
  nmu_side_t          side4_q;
  logic [63:0]        vsum;
  logic [39:0]        vsh;
  logic signed [58:0] num;
  logic [58:0]        nabs;

  assign vsum = {7'b0, b2v0_3_q} + omb2gg_q;
  assign vsh  = vsum[63:FracBits];
  assign num  = b1m_q + omb1g3_q;
  assign nabs = num[58] ? 59'(-num) : num;

  always_ff @(posedge clk_i) begin
    side4_q.res.m   <= m3_q;
    side4_q.res.v   <= (vsh[39:32] != '0) ? 32'hffff_ffff : vsh[31:0];
    side4_q.res.neg <= num[58];
    side4_q.mag     <= nabs[MagW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // ---- square root
  logic             sq_valid;
  nmu_side_t        sq_side;
  logic [RootW-1:0] sq_root;

  nmu_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v4_q),
    .in_side_i   (side4_q),
    .out_valid_o (sq_valid),
    .out_side_o  (sq_side),
    .out_root_o  (sq_root)
  );

  // ---- stage A: denominator, split numerator product
  logic              va_q, vb_q, vc_q;
  nmu_res_t          resa_q, resb_q, resc_q;
  logic [DenW-1:0]   den_q;
  logic [56:0]       plo_q;
  logic [49:0]       phi_q;

  always_ff @(posedge clk_i) begin
    resa_q <= sq_side.res;
    den_q  <= DenW'(sq_root) + DenW'(eps_eff);
    plo_q  <= sq_side.mag[31:0] * learning_rate_q;
    phi_q  <= sq_side.mag[MagW-1:32] * learning_rate_q;
  end

  // ---- stage B: divisor and dividend
  logic [DivW-1:0]  dvs_q;
  logic [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    resb_q <= resa_q;
    dvs_q  <= bc_eff * den_q;
    prod_q <= {phi_q, 32'b0} + ProdW'(plo_q);
  end

  // ---- stage C: overflow check before the divider
  logic                ovf_c_q;
  logic [DivW-1:0]     rem_c_q, dvs_c_q;
  logic [DivSteps-1:0] low_c_q;
  logic [DivW-1:0]     prod_top;

  assign prod_top = DivW'(prod_q[ProdW-1:DivSteps]);

  always_ff @(posedge clk_i) begin
    resc_q  <= resb_q;
    ovf_c_q <= prod_top >= dvs_q;
    rem_c_q <= prod_top;
    low_c_q <= prod_q[DivSteps-1:0];
    dvs_c_q <= dvs_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= sq_valid;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  // ---- divider
  logic                dv_valid, dv_ovf;
  nmu_res_t            dv_res;
  logic [DivSteps-1:0] dv_quot;

  nmu_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vc_q),
    .in_res_i    (resc_q),
    .in_ovf_i    (ovf_c_q),
    .in_rem_i    (rem_c_q),
    .in_low_i    (low_c_q),
    .in_div_i    (dvs_c_q),
    .out_valid_o (dv_valid),
    .out_res_o   (dv_res),
    .out_ovf_o   (dv_ovf),
    .out_quot_o  (dv_quot)
  );

  // ---- output: saturate and apply sign
  logic [DivSteps-1:0] limit, qsat;

  assign limit = dv_res.neg ? DivSteps'(33'h0_8000_0000) : DivSteps'(33'h0_7fff_ffff);
  assign qsat  = (dv_ovf || dv_quot > limit) ? limit : dv_quot;

  always_ff @(posedge clk_i) begin
    new_first_moment_o  <= dv_res.m;
    new_second_moment_o <= dv_res.v;
    step_value_o        <= dv_res.neg ? 32'(-qsat) : qsat[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= dv_valid;
    end
  end

`ifndef SYNTHESIS
  a_result_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i, Latency))
    else $error("result without a matching start");
  a_start_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##Latency valid_o)
    else $error("started item produced no result");
  a_zero_rate_zero_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && learning_rate_q == '0) |-> (step_value_o == '0))
    else $error("nonzero step with zero learning rate");
`endif

endmodule
